[hw/rtl/mdsc_pkg.sv]
package mdsc_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 8;

  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_LPAREN = "(";
  localparam logic [7:0] CHAR_RPAREN = ")";
  localparam logic [7:0] CHAR_SEMI   = ";";
  localparam logic [7:0] CHAR_ARRAY  = "[";
  localparam logic [7:0] CHAR_OBJECT = "L";
  localparam logic [7:0] CHAR_LONG   = "J";
  localparam logic [7:0] CHAR_DOUBLE = "D";
  localparam logic [7:0] CHAR_BYTE   = "B";
  localparam logic [7:0] CHAR_CHAR   = "C";
  localparam logic [7:0] CHAR_FLOAT  = "F";
  localparam logic [7:0] CHAR_INT    = "I";
  localparam logic [7:0] CHAR_SHORT  = "S";
  localparam logic [7:0] CHAR_BOOL   = "Z";

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_ARGS   = 4'b0010,
    MODE_OBJECT = 4'b0100,
    MODE_ARRAY  = 4'b1000
  } mode_t;

  function automatic logic is_single_slot(input logic [7:0] c);
    return (c == CHAR_BYTE) || (c == CHAR_CHAR) || (c == CHAR_FLOAT) ||
           (c == CHAR_INT) || (c == CHAR_SHORT) || (c == CHAR_BOOL);
  endfunction

  function automatic logic is_double_slot(input logic [7:0] c);
    return (c == CHAR_LONG) || (c == CHAR_DOUBLE);
  endfunction

endpackage

[hw/rtl/mdsc_char_if.sv]
interface mdsc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       start_req;

  modport source (output valid, output char_code, output start_req, input ready);
  modport sink (input valid, input char_code, input start_req, output ready);
endinterface

[hw/rtl/mdsc_result_if.sv]
interface mdsc_result_if
  import mdsc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
);
  logic                   valid;
  logic                   ready;
  logic [COUNT_WIDTH-1:0] slot_count;
  logic                   malformed;

  modport source (output valid, output slot_count, output malformed, input ready);
  modport sink (input valid, input slot_count, input malformed, output ready);
endinterface

[hw/rtl/method_descriptor_slot_counter.sv]
// Method descriptor slot counter.
// The chars channel carries one descriptor character per item, with start_req
// set on the first character of each descriptor. The results channel carries
// one item per descriptor: the number of argument slots, saturating at
// 2^COUNT_WIDTH - 1, or malformed with a zero count.
// A result is given when ')' or NUL ends the argument list, or at the first
// bad character. Characters after it are dropped until the next start.
// Each character is decoded in the cycle it is accepted; its result, if any,
// is presented in the next cycle from the output register.
// One character is taken per cycle while chars.ready is high. A new character
// is accepted while a result waits, as long as the output register is empty
// or is being taken in the same cycle.
// When the receiver stalls, the result holds and chars.ready drops only if
// the waiting result has not been taken.
// Synchronous reset returns the parser to idle, clears the count and empties
// the output register.
module method_descriptor_slot_counter
  import mdsc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input logic            clk,
  input logic            rst,
  mdsc_char_if.sink      chars,
  mdsc_result_if.source  results
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  mode_t                  mode;
  mode_t                  mode_next;
  logic [COUNT_WIDTH-1:0] slot_total;
  logic [COUNT_WIDTH-1:0] slot_total_next;
  logic                   res_valid;
  logic [COUNT_WIDTH-1:0] res_count;
  logic                   res_bad;

  logic                   accept;
  logic                   emit;
  logic                   emit_bad;
  logic [1:0]             add_n;
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] sat_total;

  assign chars.ready = !res_valid || results.ready;
  assign accept      = chars.valid && chars.ready;

  assign sum       = {1'b0, slot_total} + {{(COUNT_WIDTH-1){1'b0}}, add_n};
  assign sat_total = sum[COUNT_WIDTH] ? COUNT_MAX : sum[COUNT_WIDTH-1:0];

  always_comb begin
    mode_next       = mode;
    slot_total_next = slot_total;
    emit            = 1'b0;
    emit_bad        = 1'b0;
    add_n           = 2'd0;
    if (chars.start_req) begin
      slot_total_next = '0;
      if (chars.char_code == CHAR_LPAREN) begin
        mode_next = MODE_ARGS;
      end else begin
        emit      = 1'b1;
        emit_bad  = 1'b1;
        mode_next = MODE_IDLE;
      end
    end else begin
      unique case (mode)
        MODE_ARGS: begin
          if (chars.char_code == CHAR_NUL || chars.char_code == CHAR_RPAREN) begin
            emit      = 1'b1;
            mode_next = MODE_IDLE;
          end else if (is_single_slot(chars.char_code)) begin
            add_n = 2'd1;
          end else if (is_double_slot(chars.char_code)) begin
            add_n = 2'd2;
          end else if (chars.char_code == CHAR_OBJECT) begin
            add_n     = 2'd1;
            mode_next = MODE_OBJECT;
          end else if (chars.char_code == CHAR_ARRAY) begin
            add_n     = 2'd1;
            mode_next = MODE_ARRAY;
          end else begin
            emit      = 1'b1;
            emit_bad  = 1'b1;
            mode_next = MODE_IDLE;
          end
          slot_total_next = sat_total;
        end
        MODE_OBJECT: begin
          if (chars.char_code == CHAR_NUL) begin
            emit      = 1'b1;
            mode_next = MODE_IDLE;
          end else if (chars.char_code == CHAR_SEMI) begin
            mode_next = MODE_ARGS;
          end
        end
        MODE_ARRAY: begin
          if (chars.char_code == CHAR_NUL) begin
            emit      = 1'b1;
            mode_next = MODE_IDLE;
          end else if (chars.char_code == CHAR_OBJECT) begin
            mode_next = MODE_OBJECT;
          end else if (is_single_slot(chars.char_code) ||
                       is_double_slot(chars.char_code)) begin
            mode_next = MODE_ARGS;
          end else if (chars.char_code != CHAR_ARRAY) begin
            emit      = 1'b1;
            emit_bad  = 1'b1;
            mode_next = MODE_IDLE;
          end
        end
        default: begin
          mode_next = MODE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      slot_total <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (accept) begin
        mode       <= mode_next;
        slot_total <= slot_total_next;
      end
      if (accept && emit) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res_count <= emit_bad ? '0 : slot_total_next;
      res_bad   <= emit_bad;
    end
  end

  assign results.valid      = res_valid;
  assign results.slot_count = res_count;
  assign results.malformed  = res_bad;

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.malformed |-> results.slot_count == '0)
    else $error("malformed result with nonzero slot count");

  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    accept && emit |=> mode == MODE_IDLE && res_valid)
    else $error("parser not idle after giving a result");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    accept && !chars.start_req |=> slot_total >= $past(slot_total))
    else $error("slot count decreased within a descriptor");

  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    accept && mode == MODE_IDLE && !chars.start_req |-> !emit)
    else $error("result given for a character while idle");

endmodule
